@@ hw/rtl/mvm_pkg.sv @@
package mvm_pkg;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_VECTOR = 1'b1;

	localparam logic REG_ACTIVE_ROWS = 1'b0;
	localparam logic REG_ACTIVE_COLS = 1'b1;

	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W      = 2;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOB = 2'd1,
		ST_LEN = 2'd2,
		ST_SAT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_MWRITE   = 2'd0,
		CMD_VSTORE   = 2'd1,
		CMD_OOB      = 2'd2,
		CMD_MISMATCH = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               run;
		logic [3:0]         row_sel;
		logic [3:0]         col_sel;
		logic signed [31:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_EMIT
	} back_state_t;

endpackage

@@ hw/rtl/mvm_front.sv @@
module mvm_front #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [3:0]                         row_sel,
	input  logic [3:0]                         col_sel,
	input  logic signed [31:0]                 operand_value,
	input  logic                               vector_end,
	input  logic [$clog2(MAX_ROWS + 1) - 1:0]  rows,
	input  logic [$clog2(MAX_COLS + 1) - 1:0]  cols,
	input  logic                               clearing,
	input  logic                               cmd_full,
	output logic                               cmd_push,
	output mvm_pkg::cmd_t                      cmd
);

	localparam int VCW = $clog2(MAX_COLS + 2);

	logic [VCW - 1:0] cnt_q;
	logic [VCW - 1:0] cnt_inc;
	logic [VCW - 1:0] cnt_d;
	logic             accept;
	logic             do_push;

	assign in_ready = !cmd_full && !clearing;
	assign accept   = in_valid && in_ready;
	assign cnt_inc  = (32'(cnt_q) <= MAX_COLS) ? cnt_q + VCW'(1) : cnt_q;

	always_comb begin
		cmd.kind    = mvm_pkg::CMD_MWRITE;
		cmd.run     = 1'b0;
		cmd.row_sel = row_sel;
		cmd.col_sel = col_sel;
		cmd.value   = operand_value;
		do_push     = 1'b0;
		cnt_d       = cnt_q;
		if (mode == mvm_pkg::MODE_WRITE) begin
			do_push = 1'b1;
			if (32'(row_sel) >= 32'(rows) || 32'(col_sel) >= 32'(cols))
				cmd.kind = mvm_pkg::CMD_OOB;
		end else if (vector_end) begin
			do_push = 1'b1;
			cnt_d   = '0;
			if (32'(cnt_inc) != 32'(cols)) begin
				cmd.kind = mvm_pkg::CMD_MISMATCH;
			end else begin
				cmd.kind = mvm_pkg::CMD_VSTORE;
				cmd.run  = 1'b1;
			end
		end else begin
			cmd.kind = mvm_pkg::CMD_VSTORE;
			do_push  = 32'(cnt_q) < MAX_COLS;
			cnt_d    = cnt_inc;
		end
	end

	assign cmd_push = accept && do_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (accept)
			cnt_q <= cnt_d;
	end

endmodule

@@ hw/rtl/mvm_fifo.sv @@
module mvm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvm_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output mvm_pkg::cmd_t rd_data
);

	localparam int PW = mvm_pkg::CMD_PTR_W;
	localparam int CW = PW + 1;

	mvm_pkg::cmd_t                   entry_q [mvm_pkg::CMD_FIFO_DEPTH];
	logic [mvm_pkg::CMD_PTR_W - 1:0] wr_ptr_q;
	logic [mvm_pkg::CMD_PTR_W - 1:0] rd_ptr_q;
	logic [mvm_pkg::CMD_PTR_W:0]     count_q;

	assign full     = 32'(count_q) == mvm_pkg::CMD_FIFO_DEPTH;
	assign rd_valid = count_q != '0;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ hw/rtl/mvm_back.sv @@
module mvm_back #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  mvm_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	input  logic [$clog2(MAX_ROWS + 1) - 1:0]  rows,
	input  logic [$clog2(MAX_COLS + 1) - 1:0]  cols,
	output logic                               clearing,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [31:0]                 product_value,
	output logic [3:0]                         result_row,
	output mvm_pkg::status_t                   status,
	output logic                               final_result
);

	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW  = RAW + CAW;
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int MEM_DEPTH  = 1 << AW;
	localparam int VBUF_DEPTH = 1 << CAW;
	localparam logic signed [63:0] ACC_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_0000_8000;

	mvm_pkg::back_state_t state_q, state_d;

	logic signed [31:0] mat_mem [MEM_DEPTH];
	logic signed [31:0] vbuf    [VBUF_DEPTH];

	logic [AW - 1:0]  clr_addr_q;
	logic [RAW - 1:0] row_q;
	logic [CAW - 1:0] col_q;
	logic [CAW - 1:0] vptr_q;
	logic [RNW - 1:0] rows_q;
	logic [CNW - 1:0] cols_q;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] mat_rd_s1, vec_rd_s1;
	logic signed [63:0] prod_s2;
	logic signed [63:0] rnd_s3;
	logic signed [63:0] acc_q;

	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [3:0]         out_row_q;
	mvm_pkg::status_t   out_status_q;
	logic               out_last_q;

	logic            out_free;
	logic            last_col, last_row;
	logic            clr_we, mat_we, vec_we, run_start, issue, err_load, row_load;
	logic [AW - 1:0] wr_addr;
	logic [AW - 1:0] rd_addr;
	logic signed [31:0] sat_value;
	mvm_pkg::status_t   sat_status;

	assign out_free = !out_valid_q || out_ready;
	assign last_col = 32'(col_q) + 32'd1 == 32'(cols_q);
	assign last_row = 32'(row_q) + 32'd1 == 32'(rows_q);
	assign wr_addr  = {RAW'(cmd.row_sel), CAW'(cmd.col_sel)};
	assign rd_addr  = {row_q, col_q};
	assign clearing = state_q == mvm_pkg::BK_CLEAR;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mvm_pkg::BK_CLEAR:
				if (clr_addr_q == '1)
					state_d = mvm_pkg::BK_IDLE;
			mvm_pkg::BK_IDLE:
				if (cmd_valid && cmd.kind == mvm_pkg::CMD_VSTORE && cmd.run)
					state_d = mvm_pkg::BK_ISSUE;
			mvm_pkg::BK_ISSUE:
				if (last_col)
					state_d = mvm_pkg::BK_DRAIN;
			mvm_pkg::BK_DRAIN:
				if (!valid_s1 && !valid_s2 && !valid_s3)
					state_d = mvm_pkg::BK_EMIT;
			mvm_pkg::BK_EMIT:
				if (out_free)
					state_d = last_row ? mvm_pkg::BK_IDLE : mvm_pkg::BK_ISSUE;
			default:
				state_d = mvm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		clr_we    = 1'b0;
		cmd_pop   = 1'b0;
		mat_we    = 1'b0;
		vec_we    = 1'b0;
		run_start = 1'b0;
		issue     = 1'b0;
		err_load  = 1'b0;
		row_load  = 1'b0;
		unique case (state_q)
			mvm_pkg::BK_CLEAR:
				clr_we = 1'b1;
			mvm_pkg::BK_IDLE:
				if (cmd_valid) begin
					unique case (cmd.kind)
						mvm_pkg::CMD_MWRITE: begin
							mat_we  = 1'b1;
							cmd_pop = 1'b1;
						end
						mvm_pkg::CMD_VSTORE: begin
							vec_we    = 1'b1;
							cmd_pop   = 1'b1;
							run_start = cmd.run;
						end
						mvm_pkg::CMD_OOB, mvm_pkg::CMD_MISMATCH: begin
							err_load = out_free;
							cmd_pop  = out_free;
						end
						default: ;
					endcase
				end
			mvm_pkg::BK_ISSUE:
				issue = 1'b1;
			mvm_pkg::BK_DRAIN: ;
			mvm_pkg::BK_EMIT:
				row_load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		sat_value  = acc_q[31:0];
		sat_status = mvm_pkg::ST_OK;
		if (acc_q > ACC_MAX) begin
			sat_value  = ACC_MAX[31:0];
			sat_status = mvm_pkg::ST_SAT;
		end else if (acc_q < ACC_MIN) begin
			sat_value  = ACC_MIN[31:0];
			sat_status = mvm_pkg::ST_SAT;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_we)
			mat_mem[clr_addr_q] <= '0;
		else if (mat_we)
			mat_mem[wr_addr] <= cmd.value;
		mat_rd_s1 <= mat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vec_we)
			vbuf[vptr_q] <= cmd.value;
		vec_rd_s1 <= vbuf[col_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mat_rd_s1 * vec_rd_s1;
		rnd_s3  <= (prod_s2 + ROUND_HALF) >>> 16;
		if (run_start || row_load)
			acc_q <= '0;
		else if (valid_s3)
			acc_q <= acc_q + rnd_s3;
		if (run_start) begin
			rows_q <= rows;
			cols_q <= cols;
		end
		if (err_load) begin
			out_value_q  <= '0;
			out_row_q    <= (cmd.kind == mvm_pkg::CMD_OOB) ? cmd.row_sel : 4'd0;
			out_status_q <= (cmd.kind == mvm_pkg::CMD_OOB) ? mvm_pkg::ST_OOB
			                                                 : mvm_pkg::ST_LEN;
			out_last_q   <= 1'b1;
		end else if (row_load) begin
			out_value_q  <= sat_value;
			out_row_q    <= 4'(row_q);
			out_status_q <= sat_status;
			out_last_q   <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvm_pkg::BK_CLEAR;
			clr_addr_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			vptr_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (clr_we)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (vec_we)
				vptr_q <= run_start ? '0 : vptr_q + CAW'(1);
			else if (err_load && cmd.kind == mvm_pkg::CMD_MISMATCH)
				vptr_q <= '0;
			if (run_start) begin
				row_q <= '0;
				col_q <= '0;
			end else if (issue) begin
				col_q <= last_col ? '0 : col_q + CAW'(1);
			end else if (row_load && !last_row) begin
				row_q <= row_q + RAW'(1);
			end
			if (err_load || row_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = out_value_q;
	assign result_row    = out_row_q;
	assign status        = out_status_q;
	assign final_result  = out_last_q;

endmodule

@@ hw/rtl/matrix_vector_multiply.sv @@
// Dense matrix times vector in signed Q16.16. A request with tuser 0 writes one matrix
// element (refused with status 1 outside the active rows and columns); tuser 1 requests
// stream the vector, tlast on the last element. The last element starts one dot product
// per active row (a vector whose length is not the active column count is refused with
// status 2): one multiply-accumulate per cycle within a row on the single read port of
// the matrix memory, each product passing the read, multiply, round and accumulate
// registers before the row's sum is loaded as a result. Products are rounded half up to
// Q16.16, summed in 64 bits and saturated to 32 bits (status 3). After reset all
// 2^(ceil(log2 MAX_ROWS) + ceil(log2 MAX_COLS)) entries of the matrix memory, 256 at the
// defaults, are cleared, during which no request is taken; configuration writes are
// taken at any time but must only be issued while the block is idle.
module matrix_vector_multiply #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row_sel[3:0], col_sel[7:4], operand_value[39:8]
	input  logic        s_axis_tuser,  // mode
	input  logic        s_axis_tlast,  // vector_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // product_value[31:0], result_row[35:32], zero
	output logic [1:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast   // final_result
);

	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CNW = $clog2(MAX_COLS + 1);

	logic [4:0]       active_rows_q;
	logic [4:0]       active_cols_q;
	logic [RNW - 1:0] rows;
	logic [CNW - 1:0] cols;

	logic               clearing;
	logic               cmd_push, cmd_full, cmd_pop, cmd_valid;
	mvm_pkg::cmd_t      cmd_in, cmd_out;
	logic signed [31:0] product_value;
	logic [3:0]         result_row;
	mvm_pkg::status_t   status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= 5'd16;
			active_cols_q <= 5'd16;
		end else if (cfg_we) begin
			if (cfg_index == mvm_pkg::REG_ACTIVE_ROWS)
				active_rows_q <= cfg_data;
			if (cfg_index == mvm_pkg::REG_ACTIVE_COLS)
				active_cols_q <= cfg_data;
		end
	end

	always_comb begin
		if (active_rows_q == '0)
			rows = RNW'(1);
		else if (32'(active_rows_q) > MAX_ROWS)
			rows = RNW'(MAX_ROWS);
		else
			rows = RNW'(active_rows_q);
		if (active_cols_q == '0)
			cols = CNW'(1);
		else if (32'(active_cols_q) > MAX_COLS)
			cols = CNW'(MAX_COLS);
		else
			cols = CNW'(active_cols_q);
	end

	mvm_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.mode          (s_axis_tuser),
		.row_sel       (s_axis_tdata[3:0]),
		.col_sel       (s_axis_tdata[7:4]),
		.operand_value (s_axis_tdata[39:8]),
		.vector_end    (s_axis_tlast),
		.rows          (rows),
		.cols          (cols),
		.clearing      (clearing),
		.cmd_full      (cmd_full),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	mvm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.wr_data  (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_data  (cmd_out)
	);

	mvm_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd_out),
		.cmd_pop       (cmd_pop),
		.rows          (rows),
		.cols          (cols),
		.clearing      (clearing),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.product_value (product_value),
		.result_row    (result_row),
		.status        (status),
		.final_result  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, result_row, product_value};
	assign m_axis_tuser = status;

`ifndef SYNTH
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("request taken during matrix clear");

	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command queue underflow");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mvm_pkg::ST_OOB || m_axis_tuser == mvm_pkg::ST_LEN)
		|-> m_axis_tlast)
		else $error("error result not marked final");
`endif

endmodule
